@@ rtl/thermistor_temperature_converter_macros.svh @@
// Assertion macros used by the converter RTL
`ifndef THERMISTOR_TEMPERATURE_CONVERTER_MACROS_SVH
`define THERMISTOR_TEMPERATURE_CONVERTER_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define TTC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent after the delay given by dly
`define TTC_ASSERT_DELAY(name, ante, dly, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

@@ rtl/ttc_pkg.sv @@
// Types and constants of the thermistor temperature converter
package ttc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SERIES_RES    = 3'd0,
        CFG_NOMINAL_RES   = 3'd1,
        CFG_NOMINAL_TEMP  = 3'd2,
        CFG_BETA          = 3'd3,
        CFG_DIV_TO_SUPPLY = 3'd4
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int RES_W       = 20;
    localparam int TNOM_W      = 15;
    localparam int BETA_W      = 14;
    localparam int TEMP_W      = 16;
    localparam int FRAC_W      = 24;

    // reset values of the registers
    localparam logic [RES_W-1:0]         SERIES_RESET  = 20'd10000;
    localparam logic [RES_W-1:0]         NOMINAL_RESET = 20'd10000;
    localparam logic signed [TNOM_W-1:0] TNOM_RESET    = 15'sd2500;
    localparam logic [BETA_W-1:0]        BETA_RESET    = 14'd3950;

    // ln 2 in Q30
    localparam int          LN2_W   = 30;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // 0 degC in hundredths of a kelvin
    localparam logic [15:0] KELVIN_OFFSET = 16'd27315;

    // 100 * 2^40, numerator of both reciprocals
    localparam int          TNUM_W   = 47;
    localparam logic [46:0] TEMP_NUM = 47'd100 << 40;
    localparam int          T0K_W    = 16;

    // quotient clamp 2^40
    localparam int          QCL_W   = 41;
    localparam logic [40:0] Q_LIMIT = 41'd1 << 40;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

    // flags carried alongside a word through the dividers
    typedef struct packed {
        logic ok;
        logic zero;
        logic neg;
    } flags_t;

endpackage

@@ rtl/ttc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage
module ttc_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_sb,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_sb
);

    // stage 0 is the input register, stage j has done j steps
    logic [NW:0]   valid_reg;
    logic [NW:0]   valid_next;
    logic [DW-1:0] rem_reg  [0:NW];
    logic [DW-1:0] rem_next [0:NW];
    logic [NW-1:0] nq_reg   [0:NW];
    logic [NW-1:0] nq_next  [0:NW];
    logic [DW-1:0] den_reg  [0:NW];
    logic [DW-1:0] den_next [0:NW];
    logic [SW-1:0] sb_reg   [0:NW];
    logic [SW-1:0] sb_next  [0:NW];

    // one trial subtraction per stage; numerator shifts out, quotient shifts in
    always_comb
    begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        valid_next  = {valid_reg[NW-1:0], in_valid};
        rem_next[0] = '0;
        nq_next[0]  = in_num;
        den_next[0] = in_den;
        sb_next[0]  = in_sb;
        for (int j = 1; j <= NW; j++)
        begin
            trial       = {rem_reg[j-1], nq_reg[j-1][NW-1]};
            diff        = trial - {1'b0, den_reg[j-1]};
            den_next[j] = den_reg[j-1];
            sb_next[j]  = sb_reg[j-1];
            if (trial >= {1'b0, den_reg[j-1]})
            begin
                rem_next[j] = diff[DW-1:0];
                nq_next[j]  = {nq_reg[j-1][NW-2:0], 1'b1};
            end
            else
            begin
                rem_next[j] = trial[DW-1:0];
                nq_next[j]  = {nq_reg[j-1][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_next;
        sb_reg  <= sb_next;
    end

    assign out_valid = valid_reg[NW];
    assign out_quo   = nq_reg[NW];
    assign out_sb    = sb_reg[NW];

endmodule

@@ rtl/ttc_log2.sv @@
// Pipelined log2 in Q.24: leading-one search, then one squaring per fraction bit
module ttc_log2 #(
    parameter int VW = 52,
    parameter int SW = 1,
    parameter int EW = $clog2(VW)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [VW-1:0]                   in_value,
    input  logic [SW-1:0]                   in_sb,
    output logic                            out_valid,
    output logic [EW+ttc_pkg::FRAC_W-1:0]   out_log,
    output logic [SW-1:0]                   out_sb
);

    localparam int CH = (VW + 7) / 8;
    localparam int PW = CH * 8;
    localparam int FW = ttc_pkg::FRAC_W;
    localparam int NV = FW + 4;

    // valid chain: A, B, C, D, then one per squaring
    logic [NV-1:0] vld_reg;
    logic [NV-1:0] vld_next;

    logic [VW-1:0] a_val_reg;
    logic [SW-1:0] a_sb_reg;

    logic [CH-1:0] b_nz_reg;
    logic [CH-1:0] b_nz_next;
    logic [2:0]    b_idx_reg  [0:CH-1];
    logic [2:0]    b_idx_next [0:CH-1];
    logic [VW-1:0] b_val_reg;
    logic [SW-1:0] b_sb_reg;

    logic [EW-1:0] c_e_reg;
    logic [EW-1:0] c_e_next;
    logic [VW-1:0] c_val_reg;
    logic [SW-1:0] c_sb_reg;

    logic [VW+30:0] shifted;

    logic [31:0]   m_reg     [0:FW];
    logic [31:0]   m_next    [0:FW];
    logic [FW-1:0] frac_reg  [0:FW];
    logic [FW-1:0] frac_next [0:FW];
    logic [EW-1:0] e_reg     [0:FW];
    logic [EW-1:0] e_next    [0:FW];
    logic [SW-1:0] sb_reg    [0:FW];
    logic [SW-1:0] sb_next   [0:FW];

    assign vld_next = {vld_reg[NV-2:0], in_valid};

    // chunk flags and top bit within each byte
    always_comb
    begin
        logic [PW-1:0] padded;
        logic [7:0]    chunk;
        padded = PW'(a_val_reg);
        for (int c = 0; c < CH; c++)
        begin
            chunk         = padded[c*8 +: 8];
            b_nz_next[c]  = |chunk;
            b_idx_next[c] = 3'd0;
            for (int k = 0; k < 8; k++)
            begin
                if (chunk[k])
                    b_idx_next[c] = 3'(k);
            end
        end
    end

    // highest non-empty byte gives the exponent
    always_comb
    begin
        c_e_next = '0;
        for (int c = 0; c < CH; c++)
        begin
            if (b_nz_reg[c])
                c_e_next = EW'(c * 8) + EW'(b_idx_reg[c]);
        end
    end

    // mantissa in Q1.31, then the squaring steps
    assign shifted = {c_val_reg, 31'b0} >> c_e_reg;

    always_comb
    begin
        logic [63:0] sq;
        logic [32:0] t;
        m_next[0]    = shifted[31:0];
        frac_next[0] = '0;
        e_next[0]    = c_e_reg;
        sb_next[0]   = c_sb_reg;
        for (int i = 1; i <= FW; i++)
        begin
            sq         = m_reg[i-1] * m_reg[i-1];
            t          = sq[63:31];
            e_next[i]  = e_reg[i-1];
            sb_next[i] = sb_reg[i-1];
            if (t[32])
            begin
                m_next[i]    = t[32:1];
                frac_next[i] = {frac_reg[i-1][FW-2:0], 1'b1};
            end
            else
            begin
                m_next[i]    = t[31:0];
                frac_next[i] = {frac_reg[i-1][FW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        // zero counts as one
        a_val_reg <= (in_value == '0) ? VW'(1) : in_value;
        a_sb_reg  <= in_sb;
        b_nz_reg  <= b_nz_next;
        b_idx_reg <= b_idx_next;
        b_val_reg <= a_val_reg;
        b_sb_reg  <= a_sb_reg;
        c_e_reg   <= c_e_next;
        c_val_reg <= b_val_reg;
        c_sb_reg  <= b_sb_reg;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        e_reg     <= e_next;
        sb_reg    <= sb_next;
    end

    assign out_valid = vld_reg[NV-1];
    assign out_log   = {e_reg[FW], frac_reg[FW]};
    assign out_sb    = sb_reg[FW];

endmodule

@@ rtl/thermistor_temperature_converter.sv @@
// Top level of the thermistor temperature converter (beta equation)
//
// Takes one ADC sample per cycle whenever start is high and busy is low; busy
// is high only while reset is applied and for the cycle after it. Each sample
// gives exactly one result word on temperature/valid_res, marked by done for
// one cycle. The sample path runs through the four bit-per-stage dividers
// (divider ratio, supply-side resistance, ln/beta and the final reciprocal)
// and the 28-stage log2 unit with its 24-step squaring chain. Results cannot
// be held off. Configuration writes take effect at once; words must not be in
// flight during a write. Constants derived from nominal_resistance and
// nominal_temp come from free-running units and settle long before a new
// sample needs them.
`include "thermistor_temperature_converter_macros.svh"

module thermistor_temperature_converter #(
    parameter int ADC_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ADC_BITS-1:0]                  adc_sample,
    input  logic                                 cfg_write,
    input  logic [ttc_pkg::CFG_INDEX_W-1:0]      cfg_addr,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output logic                                 done,
    output logic signed [ttc_pkg::TEMP_W-1:0]    temperature,
    output logic                                 valid_res
);

    localparam int SER_W = ttc_pkg::RES_W;
    localparam int R_W   = ADC_BITS + 16;
    localparam int RQ_W  = (SER_W + R_W > SER_W + 32) ? SER_W + R_W : SER_W + 32;
    localparam int EW    = $clog2(RQ_W);
    localparam int LG_W  = EW + ttc_pkg::FRAC_W;
    localparam int EW0   = $clog2(SER_W);
    localparam int LG0_W = EW0 + ttc_pkg::FRAC_W;
    localparam int L2_W  = LG_W + 2;
    localparam int MAG_W = L2_W - 1;
    localparam int LP_W  = MAG_W + ttc_pkg::LN2_W;
    localparam int T1N_W = MAG_W + 17;
    localparam int S_W   = T1N_W + 2;
    localparam int SM_W  = S_W - 1;
    localparam int QN_W  = S_W;
    localparam int FL_W  = $bits(ttc_pkg::flags_t);
    localparam int LATENCY = 37 + R_W + RQ_W + T1N_W + QN_W;

    localparam logic [ADC_BITS-1:0] FS = '1;

    // ---------------- configuration registers
    logic [SER_W-1:0]                  series_resistance_reg;
    logic [SER_W-1:0]                  nominal_resistance_reg;
    logic signed [ttc_pkg::TNOM_W-1:0] nominal_temp_reg;
    logic [ttc_pkg::BETA_W-1:0]        beta_reg;
    logic                              divider_to_supply_reg;
    logic                              busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_resistance_reg  <= ttc_pkg::SERIES_RESET;
            nominal_resistance_reg <= ttc_pkg::NOMINAL_RESET;
            nominal_temp_reg       <= ttc_pkg::TNOM_RESET;
            beta_reg               <= ttc_pkg::BETA_RESET;
            divider_to_supply_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                ttc_pkg::CFG_SERIES_RES:
                    series_resistance_reg <= cfg_wdata[SER_W-1:0];
                ttc_pkg::CFG_NOMINAL_RES:
                    nominal_resistance_reg <= cfg_wdata[SER_W-1:0];
                ttc_pkg::CFG_NOMINAL_TEMP:
                    nominal_temp_reg <= $signed(cfg_wdata[ttc_pkg::TNOM_W-1:0]);
                ttc_pkg::CFG_BETA:
                    beta_reg <= cfg_wdata[ttc_pkg::BETA_W-1:0];
                ttc_pkg::CFG_DIV_TO_SUPPLY:
                    divider_to_supply_reg <= cfg_wdata[0];
                default:
                    ;
            endcase
        end
    end

    // busy only around reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy = busy_reg;

    logic accept;
    assign accept = start && !busy_reg;

    // ---------------- input register
    logic                in_valid_reg;
    logic [ADC_BITS-1:0] sample_reg;
    logic                sample_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= adc_sample;
        sample_ok_reg <= (adc_sample != '0) && (adc_sample != FS);
    end

    // ---------------- divider ratio (FS - s) / s in Q10.16
    logic            ratio_valid;
    logic [R_W-1:0]  ratio_quo;
    logic            ratio_ok;

    ttc_div #(.NW(R_W), .DW(ADC_BITS), .SW(1)) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_num    ({FS - sample_reg, 16'b0}),
        .in_den    (sample_reg),
        .in_sb     (sample_ok_reg),
        .out_valid (ratio_valid),
        .out_quo   (ratio_quo),
        .out_sb    (ratio_ok)
    );

    // ---------------- thermistor resistance, both divider orientations
    logic [R_W-1:0]       ratio_fix;
    logic [SER_W+R_W-1:0] gnd_prod;
    logic [RQ_W:0]        sup_sb_in;
    logic                 sup_valid;
    logic [RQ_W-1:0]      sup_quo;
    logic [RQ_W:0]        sup_sb;

    assign ratio_fix = (ratio_quo == '0) ? R_W'(1) : ratio_quo;
    assign gnd_prod  = series_resistance_reg * ratio_fix;
    assign sup_sb_in = {ratio_ok, RQ_W'(gnd_prod)};

    ttc_div #(.NW(RQ_W), .DW(R_W), .SW(RQ_W + 1)) u_supply_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ratio_valid),
        .in_num    (RQ_W'({series_resistance_reg, 32'b0})),
        .in_den    (ratio_fix),
        .in_sb     (sup_sb_in),
        .out_valid (sup_valid),
        .out_quo   (sup_quo),
        .out_sb    (sup_sb)
    );

    logic [RQ_W-1:0] rq;
    assign rq = divider_to_supply_reg ? sup_quo : sup_sb[RQ_W-1:0];

    // ---------------- log2 of R and of R0
    logic            lrq_valid;
    logic [LG_W-1:0] lrq;
    logic            lrq_ok;

    ttc_log2 #(.VW(RQ_W), .SW(1)) u_log_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sup_valid),
        .in_value  (rq),
        .in_sb     (sup_sb[RQ_W]),
        .out_valid (lrq_valid),
        .out_log   (lrq),
        .out_sb    (lrq_ok)
    );

    // runs freely on the register value
    logic             lr0_valid;
    logic [LG0_W-1:0] lr0;
    logic             lr0_mark;
    logic             r0_settled;

    ttc_log2 #(.VW(SER_W), .SW(1)) u_log_r0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (1'b1),
        .in_value  (nominal_resistance_reg),
        .in_sb     (1'b1),
        .out_valid (lr0_valid),
        .out_log   (lr0),
        .out_sb    (lr0_mark)
    );

    assign r0_settled = lr0_valid && lr0_mark;

    // ---------------- L2 = log2 R - log2 R0 - 16
    logic            s3_valid_reg;
    logic [L2_W-1:0] l2_reg;
    logic            s3_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= lrq_valid;
    end

    always_ff @(posedge clk)
    begin
        l2_reg    <= L2_W'(lrq) - L2_W'(lr0) - L2_W'(32'd16 << ttc_pkg::FRAC_W);
        s3_ok_reg <= lrq_ok;
    end

    // ---------------- |L2| * ln 2
    logic             l2_neg;
    logic [L2_W-1:0]  l2_abs;
    logic             s4_valid_reg;
    logic [LP_W-1:0]  ln_prod_reg;
    logic             s4_neg_reg;
    logic             s4_ok_reg;

    assign l2_neg = l2_reg[L2_W-1];
    assign l2_abs = l2_neg ? (~l2_reg + L2_W'(1)) : l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        ln_prod_reg <= l2_abs[MAG_W-1:0] * ttc_pkg::LN2_Q30;
        s4_neg_reg  <= l2_neg;
        s4_ok_reg   <= s3_ok_reg;
    end

    // ---------------- t1 = round(|ln| * 2^16 / beta)
    logic [LP_W-1:0]            ln_sum;
    logic [MAG_W-1:0]           ln_mag;
    logic [ttc_pkg::BETA_W-1:0] beta_eff;
    logic [T1N_W-1:0]           t1_num;
    ttc_pkg::flags_t            t1_flags_in;
    logic                       t1_valid;
    logic [T1N_W-1:0]           t1_quo;
    ttc_pkg::flags_t            t1_flags;

    assign ln_sum   = ln_prod_reg + LP_W'(32'd1 << 29);
    assign ln_mag   = ln_sum[LP_W-1:ttc_pkg::LN2_W];
    assign beta_eff = (beta_reg == '0) ? ttc_pkg::BETA_W'(1) : beta_reg;
    assign t1_num   = T1N_W'({ln_mag, 16'b0}) + T1N_W'(beta_eff >> 1);

    always_comb
    begin
        t1_flags_in.ok   = s4_ok_reg;
        t1_flags_in.zero = 1'b0;
        t1_flags_in.neg  = s4_neg_reg;
    end

    ttc_div #(.NW(T1N_W), .DW(ttc_pkg::BETA_W), .SW(FL_W)) u_t1_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_num    (t1_num),
        .in_den    (beta_eff),
        .in_sb     (t1_flags_in),
        .out_valid (t1_valid),
        .out_quo   (t1_quo),
        .out_sb    (t1_flags)
    );

    // ---------------- 1/T0 in Q.40, runs freely on the register value
    logic signed [16:0]          t0k_full;
    logic [ttc_pkg::T0K_W-1:0]   t0k;
    logic                        t0_valid;
    logic [ttc_pkg::TNUM_W-1:0]  t0inv;
    logic                        t0_mark;
    logic                        t0_settled;

    assign t0k_full = 17'(nominal_temp_reg) + $signed(17'(ttc_pkg::KELVIN_OFFSET));
    assign t0k      = t0k_full[ttc_pkg::T0K_W-1:0];

    ttc_div #(.NW(ttc_pkg::TNUM_W), .DW(ttc_pkg::T0K_W), .SW(1)) u_t0_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (1'b1),
        .in_num    (ttc_pkg::TEMP_NUM + ttc_pkg::TNUM_W'(t0k >> 1)),
        .in_den    (t0k),
        .in_sb     (1'b1),
        .out_valid (t0_valid),
        .out_quo   (t0inv),
        .out_sb    (t0_mark)
    );

    assign t0_settled = t0_valid && t0_mark;

    // ---------------- S = 1/T0 +- t1
    logic           s6_valid_reg;
    logic [S_W-1:0] s40_reg;
    logic           s6_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= t1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (t1_flags.neg)
            s40_reg <= S_W'(t0inv) - S_W'(t1_quo);
        else
            s40_reg <= S_W'(t0inv) + S_W'(t1_quo);
        s6_ok_reg <= t1_flags.ok;
    end

    // ---------------- T = round(100 * 2^40 / |S|)
    logic            s_neg;
    logic [S_W-1:0]  s_abs;
    logic [SM_W-1:0] s_mag;
    ttc_pkg::flags_t q_flags_in;
    logic            q_valid;
    logic [QN_W-1:0] q_quo;
    ttc_pkg::flags_t q_flags;

    assign s_neg = s40_reg[S_W-1];
    assign s_abs = s_neg ? (~s40_reg + S_W'(1)) : s40_reg;
    assign s_mag = s_abs[SM_W-1:0];

    always_comb
    begin
        q_flags_in.ok   = s6_ok_reg;
        q_flags_in.zero = (s40_reg == '0);
        q_flags_in.neg  = s_neg;
    end

    ttc_div #(.NW(QN_W), .DW(SM_W), .SW(FL_W)) u_recip_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_num    (QN_W'(ttc_pkg::TEMP_NUM) + QN_W'(s_mag >> 1)),
        .in_den    (s_mag),
        .in_sb     (q_flags_in),
        .out_valid (q_valid),
        .out_quo   (q_quo),
        .out_sb    (q_flags)
    );

    // ---------------- clamp, back to Celsius, saturate; invalid words read zero
    logic [ttc_pkg::QCL_W-1:0]        q_clamped;
    logic signed [42:0]               q_signed;
    logic signed [42:0]               temp_wide;
    logic signed [ttc_pkg::TEMP_W-1:0] temp_next;
    logic                             done_reg;
    logic signed [ttc_pkg::TEMP_W-1:0] temperature_reg;
    logic                             valid_res_reg;

    always_comb
    begin
        q_clamped = (q_quo > QN_W'(ttc_pkg::Q_LIMIT)) ? ttc_pkg::Q_LIMIT
                                                      : q_quo[ttc_pkg::QCL_W-1:0];
        q_signed  = $signed(43'(q_clamped));
        temp_wide = (q_flags.neg ? -q_signed : q_signed)
                    - $signed(43'(ttc_pkg::KELVIN_OFFSET));
        if (!q_flags.ok)
            temp_next = '0;
        else if (q_flags.zero)
            temp_next = ttc_pkg::TEMP_MAX;
        else if (temp_wide > 43'sd32767)
            temp_next = ttc_pkg::TEMP_MAX;
        else if (temp_wide < -43'sd32768)
            temp_next = ttc_pkg::TEMP_MIN;
        else
            temp_next = temp_wide[ttc_pkg::TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        temperature_reg <= temp_next;
        valid_res_reg   <= q_flags.ok;
    end

    assign done        = done_reg;
    assign temperature = temperature_reg;
    assign valid_res   = valid_res_reg;

    // ---------------- assertions
    `TTC_ASSERT_DELAY(a_latency, accept, LATENCY, done, "word lost in the pipeline")
    `TTC_ASSERT_IMPL(a_no_spurious, done, $past(accept, LATENCY), "result without a sample")
    `TTC_ASSERT_IMPL(a_r0_settled, s3_valid_reg, r0_settled, "log2 of R0 not settled")
    `TTC_ASSERT_IMPL(a_t0_settled, s6_valid_reg, t0_settled, "1/T0 not settled")
    `TTC_ASSERT_IMPL(a_invalid_zero, done && !valid_res, temperature == '0, "invalid word not zero")

endmodule

@@ bench/ttc_checker.sv @@
// Checker for the thermistor converter: watches the ports, predicts each result and compares
`timescale 1ns / 1ps

module ttc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [9:0]                        adc_sample,
    input  logic                              cfg_write,
    input  logic [ttc_pkg::CFG_INDEX_W-1:0]   cfg_addr,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              done,
    input  logic signed [ttc_pkg::TEMP_W-1:0] temperature,
    input  logic                              valid_res,
    output int                                fail_count,
    output int                                pending
);

    localparam longint unsigned FULL_SCALE = 64'd1023;
    localparam longint unsigned RECIP_NUM  = 64'd100 << 40;

    typedef struct packed {
        logic signed [ttc_pkg::TEMP_W-1:0] temp;
        logic                              valid;
    } reading_t;

    // local copy of the configuration
    logic [ttc_pkg::RES_W-1:0]         series_ohms;
    logic [ttc_pkg::RES_W-1:0]         nominal_ohms;
    logic signed [ttc_pkg::TNOM_W-1:0] nominal_centi;
    logic [ttc_pkg::BETA_W-1:0]        beta_k;
    logic                              to_supply;

    reading_t expected_readings[$];

    // log2 in Q.24 by repeated squaring of the Q1.31 mantissa
    function automatic longint unsigned log2_q24(input longint unsigned v);
        int unsigned    e;
        longint unsigned m;
        longint unsigned acc;
        e = 0;
        if (v == 0)
            v = 1;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        if (e >= 31)
            m = v >> (e - 31);
        else
            m = v << (31 - e);
        acc = longint'(e) << 24;
        for (int i = 23; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                acc = acc | (64'd1 << i);
            end
        end
        return acc;
    endfunction

    // temperature from one sample under the current settings
    function automatic reading_t convert_sample(input logic [9:0] smp);
        reading_t        res;
        longint unsigned s, ratio, rth, r0, mag, lnmag, t1, t0inv, q, b;
        longint          l2, sum, t;
        longint          t0k;
        logic            lneg, sneg;
        s = smp;
        if (s == 0 || s >= FULL_SCALE)
        begin
            res.temp = '0;
            res.valid = 1'b0;
            return res;
        end
        ratio = ((FULL_SCALE - s) << 16) / s;
        if (ratio == 0)
            ratio = 1;
        if (to_supply)
            rth = (longint'(series_ohms) << 32) / ratio;
        else
            rth = longint'(series_ohms) * ratio;
        if (rth == 0)
            rth = 1;
        r0 = (nominal_ohms != 0) ? nominal_ohms : 1;
        l2 = longint'(log2_q24(rth)) - longint'(log2_q24(r0)) - (64'sd16 <<< 24);
        lneg = l2 < 0;
        mag = lneg ? -l2 : l2;
        lnmag = (mag * ttc_pkg::LN2_Q30 + (64'd1 << 29)) >> 30;
        b = (beta_k != 0) ? beta_k : 1;
        t1 = ((lnmag << 16) + b / 2) / b;
        t0k = longint'(nominal_centi) + 27315;
        t0inv = (RECIP_NUM + t0k / 2) / t0k;
        sum = lneg ? longint'(t0inv) - longint'(t1) : longint'(t0inv) + longint'(t1);
        if (sum == 0)
            t = 32767;
        else
        begin
            sneg = sum < 0;
            mag = sneg ? -sum : sum;
            q = (RECIP_NUM + mag / 2) / mag;
            if (q > (64'd1 << 40))
                q = 64'd1 << 40;
            t = (sneg ? -longint'(q) : longint'(q)) - 27315;
        end
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        res.temp = t[15:0];
        res.valid = 1'b1;
        return res;
    endfunction

    // register writes, accepted words and result comparison
    always @(posedge clk or negedge rst_n)
    begin
        reading_t exp_r;
        int       errs;
        errs = 0;
        if (!rst_n)
        begin
            series_ohms   <= ttc_pkg::SERIES_RESET;
            nominal_ohms  <= ttc_pkg::NOMINAL_RESET;
            nominal_centi <= ttc_pkg::TNOM_RESET;
            beta_k        <= ttc_pkg::BETA_RESET;
            to_supply     <= 1'b0;
            fail_count    <= 0;
            expected_readings.delete();
            pending       <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_addr)
                    ttc_pkg::CFG_SERIES_RES:    series_ohms   <= cfg_wdata;
                    ttc_pkg::CFG_NOMINAL_RES:   nominal_ohms  <= cfg_wdata;
                    ttc_pkg::CFG_NOMINAL_TEMP:
                        nominal_centi <= cfg_wdata[ttc_pkg::TNOM_W-1:0];
                    ttc_pkg::CFG_BETA:          beta_k        <= cfg_wdata[ttc_pkg::BETA_W-1:0];
                    ttc_pkg::CFG_DIV_TO_SUPPLY: to_supply     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_readings.push_back(convert_sample(adc_sample));
            if (done)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("unexpected result word: temperature %0d valid_res %0d",
                           temperature, valid_res);
                    errs = errs + 1;
                end
                else
                begin
                    exp_r = expected_readings.pop_front();
                    if (temperature !== exp_r.temp)
                    begin
                        $error("temperature: expected %0d, got %0d", exp_r.temp, temperature);
                        errs = errs + 1;
                    end
                    if (valid_res !== exp_r.valid)
                    begin
                        $error("valid_res: expected %0d, got %0d", exp_r.valid, valid_res);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= expected_readings.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
// Top of the thermistor converter bench: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 4000;
    localparam int PHASES     = 8;
    localparam int PER_PHASE  = 118;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [9:0]                        adc_sample;
    logic                              cfg_write;
    logic [ttc_pkg::CFG_INDEX_W-1:0]   cfg_addr;
    logic [ttc_pkg::CFG_DATA_W-1:0]    cfg_wdata;
    logic                              done;
    logic signed [ttc_pkg::TEMP_W-1:0] temperature;
    logic                              valid_res;
    logic                              busy_seen;
    int                                fail_count;
    int                                pending;
    int                                idle_cycles;

    thermistor_temperature_converter #(.ADC_BITS(10)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .adc_sample(adc_sample),
        .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .done(done), .temperature(temperature), .valid_res(valid_res)
    );

    ttc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .adc_sample(adc_sample),
        .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .done(done), .temperature(temperature), .valid_res(valid_res),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // busy as it stands before the next rising edge
    always @(negedge clk)
        busy_seen <= busy;

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one sample and hold it until accepted
    task automatic send_sample(input logic [9:0] smp);
        start      <= 1'b1;
        adc_sample <= smp;
        do
            @(posedge clk);
        while (busy_seen);
    endtask

    // now and then, when allowed, drop start for a random gap
    task automatic maybe_gap(input bit allow);
        if (allow && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // one register write
    task automatic write_reg(input ttc_pkg::cfg_index_t idx, input logic [19:0] val);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // wait for the pipeline to drain, then load all five registers
    task automatic load_settings(input logic [19:0] series, input logic [19:0] nominal,
                                 input logic [14:0] tnom, input logic [13:0] beta_v,
                                 input logic to_sup);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        write_reg(ttc_pkg::CFG_SERIES_RES, series);
        write_reg(ttc_pkg::CFG_NOMINAL_RES, nominal);
        write_reg(ttc_pkg::CFG_NOMINAL_TEMP, 20'(tnom));
        write_reg(ttc_pkg::CFG_BETA, 20'(beta_v));
        write_reg(ttc_pkg::CFG_DIV_TO_SUPPLY, 20'(to_sup));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // random sample biased towards the edges of the range
    function automatic logic [9:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 10'($urandom_range(0, 3));
            1:       return 10'($urandom_range(1019, 1023));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    initial
    begin
        logic [9:0] directed[14];
        directed   = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd255, 10'd511, 10'd512,
                       10'd682, 10'd1000, 10'd1021, 10'd1022, 10'd1023,
                       10'h155, 10'h2AA};
        rst_n      = 1'b0;
        start      = 1'b0;
        adc_sample = '0;
        cfg_write  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples under the reset settings
        foreach (directed[i])
            send_sample(directed[i]);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: ;
                1: load_settings(20'd1, 20'd1000000, 15'h7FFF & (-15'sd4000), 14'd1, 1'b1);
                2: load_settings(20'd1000000, 20'd1, 15'd15000, 14'd10000, 1'b0);
                3: load_settings(20'hFFFFF, 20'd0, 15'h4000, 14'd0, 1'b1);
                4: load_settings(20'd0, 20'hFFFFF, 15'h3FFF, 14'h3FFF, 1'b0);
                default:
                    load_settings($urandom_range(0, 3) == 0 ? 20'($urandom)
                                                           : 20'($urandom_range(1, 1000000)),
                                  $urandom_range(0, 3) == 0 ? 20'($urandom)
                                                           : 20'($urandom_range(1, 1000000)),
                                  15'($urandom), 14'($urandom), 1'($urandom));
            endcase
            for (int n = 0; n < PER_PHASE; n++)
            begin
                send_sample(pick_sample());
                maybe_gap(ph < PHASES - 1);
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ttc_pkg.sv
rtl/ttc_div.sv
rtl/ttc_log2.sv
rtl/thermistor_temperature_converter.sv
bench/ttc_checker.sv
bench/testbench.sv
